### rtl/core/dtb_pkg.sv
// Package for the dominator tree builder: sizes and error codes.
// No dependencies.
`timescale 1ns / 1ps
package dtb_pkg;
    localparam int MaxNodes   = 64;
    localparam int MaxPreds   = 8;
    localparam int NodeW      = 6;
    localparam int PredSlotW  = 3;
    localparam int PcntW      = 4;
    localparam int PtabDepth  = MaxNodes * MaxPreds;
    localparam int PtabAw     = NodeW + PredSlotW;
    localparam int NtabW      = PcntW + NodeW;
    localparam int BudgetW    = 8;
    localparam int PassW      = 7;

    localparam logic [1:0] ERR_OK       = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_INDEX    = 2'd2;
endpackage

### rtl/core/dtb_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dtb_ram #(
    parameter int Width = 8,
    parameter int Depth = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### rtl/core/dominator_tree_builder.sv
// Top level of the dominator tree builder: edge load, checks, fixpoint, emit.
// Depends on dtb_pkg and dtb_ram.
//
// Usage: edges arrive one beat at a time on the input channel (valid/ready).
// S_LOAD accepts an edge and reads the node's predecessor count; the next
// cycle, S_LWR writes the edge and the bumped count with ready low, so a new
// edge is not taken until the last one is stored. The beat with last_edge set
// closes the graph and carries node_count and entry_node; the index checks
// use the largest stored node and predecessor numbers, so they are done in
// the store cycle. An error gives one error beat, loaded in S_ERR. Otherwise
// the fixpoint runs with ready low: per pass a start state, a skip for the
// entry node, and per other node an entry read, a read and check per
// predecessor, per intersect walk a read and a move per finger move and a
// final check (at most 128 moves), and a commit; up to node_count+3 passes.
// Results follow node 0 first, a read and a load step per beat, last on the
// final one. Ready returns once the final beat is in the output register.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits. Reset clears the per-node valid bits and flags; the RAMs
// need no clearing pass since the valid bits mask entries not written for the
// current graph. A read may hit an entry being written; that data is unused.
`timescale 1ns / 1ps
module dominator_tree_builder (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [dtb_pkg::NodeW-1:0]   node,
    input  logic [dtb_pkg::NodeW-1:0]   pred_node,
    input  logic [6:0]                  node_count,
    input  logic [dtb_pkg::NodeW-1:0]   entry_node,
    input  logic                        last_edge,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [dtb_pkg::NodeW-1:0]   out_node,
    output logic [dtb_pkg::NodeW-1:0]   idom,
    output logic                        reachable,
    output logic [1:0]                  error,
    output logic                        last
);
    import dtb_pkg::*;

    localparam logic [3:0] S_LOAD   = 4'd0;
    localparam logic [3:0] S_LWR    = 4'd1;   // store edge, bump count
    localparam logic [3:0] S_PSTART = 4'd2;   // start or end a pass
    localparam logic [3:0] S_NODE   = 4'd3;   // issue node entry read
    localparam logic [3:0] S_NRD    = 4'd4;   // node entry back
    localparam logic [3:0] S_PRD    = 4'd5;   // issue pred read
    localparam logic [3:0] S_PWT    = 4'd6;   // pred data back
    localparam logic [3:0] S_WALK   = 4'd7;   // issue finger read
    localparam logic [3:0] S_WWT    = 4'd8;   // move finger
    localparam logic [3:0] S_COMMIT = 4'd9;   // write node result
    localparam logic [3:0] S_EMIT   = 4'd10;  // issue result read
    localparam logic [3:0] S_EMITW  = 4'd11;  // load result beat
    localparam logic [3:0] S_ERR    = 4'd12;  // load error beat

    logic [3:0]         state_reg;
    logic [NodeW-1:0]   e_node_reg, e_pred_reg, e_ent_reg;
    logic [6:0]         e_cnt_reg;
    logic               e_last_reg;
    logic [1:0]         err_reg;
    logic               have_reg;
    logic [NodeW-1:0]   maxn_reg, maxp_reg;
    logic [MaxNodes-1:0] pv_reg;   // pred count valid for this graph
    logic [MaxNodes-1:0] dv_reg;   // dominator known for this graph
    logic [6:0]         count_reg;
    logic [NodeW-1:0]   entry_reg;
    logic [NodeW-1:0]   b_reg;
    logic [PcntW-1:0]   i_reg;
    logic [PcntW-1:0]   pcnt_b_reg;
    logic               cur_def_reg;
    logic [NodeW-1:0]   cur_idom_reg;
    logic [NodeW-1:0]   pick_reg;
    logic               pick_def_reg;
    logic [NodeW-1:0]   fa_reg, fb_reg;
    logic [BudgetW-1:0] bud_reg;
    logic               chg_reg;
    logic [PassW-1:0]   pass_reg;

    logic               ov_valid_reg;
    logic [NodeW-1:0]   ov_node_reg, ov_idom_reg;
    logic               ov_reach_reg, ov_last_reg;
    logic [1:0]         ov_err_reg;

    logic               ptab_we;
    logic [PtabAw-1:0]  ptab_waddr, ptab_raddr;
    logic [NodeW-1:0]   ptab_rdata;
    logic               ntab_we;
    logic [NodeW-1:0]   ntab_waddr, ntab_raddr;
    logic [NtabW-1:0]   ntab_wdata, ntab_rdata;

    logic in_fire, out_fire;
    logic [PcntW-1:0] cur_cnt;
    logic store, have_after, bad_graph;
    logic [NodeW-1:0] maxn_after, maxp_after;
    logic [1:0] err_edge, err_fin;
    logic fa_lt, f_def, p_def, upd;
    logic [NodeW-1:0] fmin, f_val;
    logic k_entry, k_last;
    logic [NodeW-1:0] k_idom;
    logic ov_load;
    logic [NodeW-1:0] ld_node, ld_idom;
    logic ld_reach, ld_last;
    logic [1:0] ld_err;

    assign in_ready = (state_reg == S_LOAD);
    assign in_fire  = in_valid && in_ready;
    assign out_fire = ov_valid_reg && out_ready;

    // Predecessor table: one slot per node and predecessor index.
    dtb_ram #(.Width(NodeW), .Depth(PtabDepth)) u_ptab (
        .clk   (clk),
        .we    (ptab_we),
        .waddr (ptab_waddr),
        .wdata (ptab_wdata_w),
        .raddr (ptab_raddr),
        .rdata (ptab_rdata)
    );

    // Node table: {pred count, immediate dominator} per node.
    dtb_ram #(.Width(NtabW), .Depth(MaxNodes)) u_ntab (
        .clk   (clk),
        .we    (ntab_we),
        .waddr (ntab_waddr),
        .wdata (ntab_wdata),
        .raddr (ntab_raddr),
        .rdata (ntab_rdata)
    );

    logic [NodeW-1:0] ptab_wdata_w;
    assign ptab_wdata_w = e_pred_reg;

    // Edge store and graph checks, evaluated in the store cycle.
    always_comb
    begin
        cur_cnt    = pv_reg[e_node_reg] ? ntab_rdata[NtabW-1:NodeW] : '0;
        store      = cur_cnt < PcntW'(MaxPreds);
        have_after = have_reg || store;
        maxn_after = (store && e_node_reg > maxn_reg) ? e_node_reg : maxn_reg;
        maxp_after = (store && e_pred_reg > maxp_reg) ? e_pred_reg : maxp_reg;
        err_edge   = (err_reg == ERR_OK && !store) ? ERR_OVERFLOW : err_reg;
        bad_graph  = (e_cnt_reg == 7'd0) || (e_cnt_reg > 7'(MaxNodes)) ||
                     ({1'b0, e_ent_reg} >= e_cnt_reg) ||
                     (have_after && ({1'b0, maxn_after} >= e_cnt_reg ||
                                     {1'b0, maxp_after} >= e_cnt_reg));
        err_fin    = (err_edge == ERR_OK && bad_graph) ? ERR_INDEX : err_edge;
    end

    // The entry dominates itself and is never written.
    assign fa_lt = fa_reg < fb_reg;
    assign fmin  = fa_lt ? fa_reg : fb_reg;
    assign f_def = (fmin == entry_reg) || dv_reg[fmin];
    assign f_val = (fmin == entry_reg) ? entry_reg : ntab_rdata[NodeW-1:0];
    assign p_def = (ptab_rdata == entry_reg) || dv_reg[ptab_rdata];
    assign upd   = pick_def_reg && (!cur_def_reg || cur_idom_reg != pick_reg);

    assign k_entry = (b_reg == entry_reg);
    assign k_idom  = k_entry ? entry_reg :
                     (dv_reg[b_reg] ? ntab_rdata[NodeW-1:0] : '0);
    assign k_last  = ({1'b0, b_reg} == count_reg - 7'd1);

    assign ptab_we    = (state_reg == S_LWR) && store;
    assign ptab_waddr = {e_node_reg, cur_cnt[PredSlotW-1:0]};
    assign ptab_raddr = {b_reg, i_reg[PredSlotW-1:0]};

    assign ntab_we    = ((state_reg == S_LWR) && store) ||
                        ((state_reg == S_COMMIT) && upd);
    assign ntab_waddr = (state_reg == S_LWR) ? e_node_reg : b_reg;
    assign ntab_wdata = (state_reg == S_LWR) ?
                        {cur_cnt + PcntW'(1), {NodeW{1'b0}}} :
                        {pcnt_b_reg, pick_reg};

    always_comb
    begin
        unique case (state_reg)
            S_LOAD:  ntab_raddr = node;
            S_WALK:  ntab_raddr = fmin;
            default: ntab_raddr = b_reg;
        endcase
    end

    // Output register: load a new beat when empty or being drained.
    assign ov_load = ((state_reg == S_EMITW) || (state_reg == S_ERR)) &&
                     (!ov_valid_reg || out_ready);

    always_comb
    begin
        if (state_reg == S_ERR)
        begin
            ld_node  = '0;
            ld_idom  = '0;
            ld_reach = 1'b0;
            ld_err   = err_reg;
            ld_last  = 1'b1;
        end
        else
        begin
            ld_node  = b_reg;
            ld_idom  = k_idom;
            ld_reach = k_entry || dv_reg[b_reg];
            ld_err   = ERR_OK;
            ld_last  = k_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_valid_reg <= 1'b0;
            ov_node_reg  <= '0;
            ov_idom_reg  <= '0;
            ov_reach_reg <= 1'b0;
            ov_err_reg   <= ERR_OK;
            ov_last_reg  <= 1'b0;
        end
        else if (ov_load)
        begin
            ov_valid_reg <= 1'b1;
            ov_node_reg  <= ld_node;
            ov_idom_reg  <= ld_idom;
            ov_reach_reg <= ld_reach;
            ov_err_reg   <= ld_err;
            ov_last_reg  <= ld_last;
        end
        else if (out_fire)
        begin
            ov_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            e_node_reg   <= '0;
            e_pred_reg   <= '0;
            e_cnt_reg    <= '0;
            e_ent_reg    <= '0;
            e_last_reg   <= 1'b0;
            err_reg      <= ERR_OK;
            have_reg     <= 1'b0;
            maxn_reg     <= '0;
            maxp_reg     <= '0;
            pv_reg       <= '0;
            dv_reg       <= '0;
            count_reg    <= '0;
            entry_reg    <= '0;
            b_reg        <= '0;
            i_reg        <= '0;
            pcnt_b_reg   <= '0;
            cur_def_reg  <= 1'b0;
            cur_idom_reg <= '0;
            pick_reg     <= '0;
            pick_def_reg <= 1'b0;
            fa_reg       <= '0;
            fb_reg       <= '0;
            bud_reg      <= '0;
            chg_reg      <= 1'b0;
            pass_reg     <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_LOAD:
                begin
                    // Capture the edge; its node's count read is in flight.
                    if (in_fire)
                    begin
                        e_node_reg <= node;
                        e_pred_reg <= pred_node;
                        e_cnt_reg  <= node_count;
                        e_ent_reg  <= entry_node;
                        e_last_reg <= last_edge;
                        state_reg  <= S_LWR;
                    end
                end
                S_LWR:
                begin
                    // Store the edge unless the node is full; drop it otherwise.
                    if (store)
                    begin
                        pv_reg[e_node_reg] <= 1'b1;
                        have_reg <= 1'b1;
                        maxn_reg <= maxn_after;
                        maxp_reg <= maxp_after;
                    end
                    err_reg <= e_last_reg ? err_fin : err_edge;
                    if (e_last_reg)
                    begin
                        count_reg <= e_cnt_reg;
                        entry_reg <= e_ent_reg;
                        chg_reg   <= 1'b1;
                        pass_reg  <= '0;
                        state_reg <= (err_fin != ERR_OK) ? S_ERR : S_PSTART;
                    end
                    else
                    begin
                        state_reg <= S_LOAD;
                    end
                end
                S_PSTART:
                begin
                    if (chg_reg && {1'b0, pass_reg} < {1'b0, count_reg} + 8'd3)
                    begin
                        chg_reg   <= 1'b0;
                        b_reg     <= NodeW'(count_reg - 7'd1);
                        state_reg <= S_NODE;
                    end
                    else
                    begin
                        b_reg     <= '0;
                        state_reg <= S_EMIT;
                    end
                end
                S_NODE:
                begin
                    if (b_reg != entry_reg)
                    begin
                        state_reg <= S_NRD;
                    end
                    else if (b_reg == '0)
                    begin
                        pass_reg  <= pass_reg + 1'b1;
                        state_reg <= S_PSTART;
                    end
                    else
                    begin
                        b_reg <= b_reg - 1'b1;
                    end
                end
                S_NRD:
                begin
                    pcnt_b_reg   <= pv_reg[b_reg] ? ntab_rdata[NtabW-1:NodeW] : '0;
                    cur_def_reg  <= dv_reg[b_reg];
                    cur_idom_reg <= ntab_rdata[NodeW-1:0];
                    i_reg        <= '0;
                    pick_def_reg <= 1'b0;
                    state_reg    <= S_PRD;
                end
                S_PRD:
                begin
                    state_reg <= (i_reg >= pcnt_b_reg) ? S_COMMIT : S_PWT;
                end
                S_PWT:
                begin
                    // Skip preds with no known dominator; the first known seeds.
                    i_reg <= i_reg + 1'b1;
                    if (!p_def)
                    begin
                        state_reg <= S_PRD;
                    end
                    else if (!pick_def_reg)
                    begin
                        pick_reg     <= ptab_rdata;
                        pick_def_reg <= 1'b1;
                        state_reg    <= S_PRD;
                    end
                    else
                    begin
                        fa_reg    <= ptab_rdata;
                        fb_reg    <= pick_reg;
                        bud_reg   <= BudgetW'(2 * MaxNodes);
                        state_reg <= S_WALK;
                    end
                end
                S_WALK:
                begin
                    // Stop when the fingers meet or the move budget runs out.
                    if (fa_reg == fb_reg || bud_reg == '0)
                    begin
                        pick_reg  <= fa_reg;
                        state_reg <= S_PRD;
                    end
                    else
                    begin
                        bud_reg   <= bud_reg - 1'b1;
                        state_reg <= S_WWT;
                    end
                end
                S_WWT:
                begin
                    // Advance the lower finger; hold it if its dominator is unknown.
                    if (f_def)
                    begin
                        if (fa_lt)
                        begin
                            fa_reg <= f_val;
                        end
                        else
                        begin
                            fb_reg <= f_val;
                        end
                    end
                    state_reg <= S_WALK;
                end
                S_COMMIT:
                begin
                    if (upd)
                    begin
                        dv_reg[b_reg] <= 1'b1;
                        chg_reg <= 1'b1;
                    end
                    if (b_reg == '0)
                    begin
                        pass_reg  <= pass_reg + 1'b1;
                        state_reg <= S_PSTART;
                    end
                    else
                    begin
                        b_reg     <= b_reg - 1'b1;
                        state_reg <= S_NODE;
                    end
                end
                S_EMIT:
                begin
                    state_reg <= S_EMITW;
                end
                S_EMITW:
                begin
                    if (ov_load)
                    begin
                        if (k_last)
                        begin
                            pv_reg    <= '0;
                            dv_reg    <= '0;
                            err_reg   <= ERR_OK;
                            have_reg  <= 1'b0;
                            maxn_reg  <= '0;
                            maxp_reg  <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            b_reg     <= b_reg + 1'b1;
                            state_reg <= S_EMIT;
                        end
                    end
                end
                S_ERR:
                begin
                    // Drop the graph once the error beat is loaded.
                    if (ov_load)
                    begin
                        pv_reg    <= '0;
                        dv_reg    <= '0;
                        err_reg   <= ERR_OK;
                        have_reg  <= 1'b0;
                        maxn_reg  <= '0;
                        maxp_reg  <= '0;
                        state_reg <= S_LOAD;
                    end
                end
                default: state_reg <= S_LOAD;
            endcase
        end
    end

    assign out_valid = ov_valid_reg;
    assign out_node  = ov_node_reg;
    assign idom      = ov_idom_reg;
    assign reachable = ov_reach_reg;
    assign error     = ov_err_reg;
    assign last      = ov_last_reg;

    // Edges are only taken while loading.
    a_ready_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_LOAD) else $error("ready outside load");
    // An error beat is always the final beat.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && error != ERR_OK) |-> last) else $error("error not last");
    // Unreachable results report a zero dominator.
    a_unreach: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !reachable) |-> idom == '0) else $error("bad idom");
    // Held beat does not change while stalled.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> $stable(out_node)) else $error("beat moved");
endmodule

### dv/dominator_tree_builder_test.sv
// Testbench for dominator_tree_builder: loads random and directed control-flow graphs,
// predicts immediate dominators per node and checks every result beat in order.
// Depends on dtb_pkg and the dominator_tree_builder RTL.
`timescale 1ns / 1ps
module dominator_tree_builder_test;
    import dtb_pkg::*;

    // Worst fixpoint: 67 passes x 64 nodes x 8 preds, each with a walk of up to
    // 128 finger moves, with nothing accepted; keep a wide margin.
    localparam int WatchdogLimit = 40000000;

    typedef struct packed {
        logic [5:0] node;
        logic [5:0] pred_node;
        logic [6:0] node_count;
        logic [5:0] entry_node;
        logic       last_edge;
    } edge_beat_t;

    typedef struct packed {
        logic [5:0] out_node;
        logic [5:0] idom;
        logic       reachable;
        logic [1:0] error;
        logic       last;
    } dom_beat_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [5:0] node;
    logic [5:0] pred_node;
    logic [6:0] node_count;
    logic [5:0] entry_node;
    logic last_edge;
    logic out_valid;
    logic out_ready;
    logic [5:0] out_node;
    logic [5:0] idom;
    logic reachable;
    logic [1:0] error;
    logic last;

    dominator_tree_builder i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .node(node), .pred_node(pred_node), .node_count(node_count),
        .entry_node(entry_node), .last_edge(last_edge),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_node(out_node), .idom(idom), .reachable(reachable),
        .error(error), .last(last)
    );

    // Predictor state: a private copy of the graph being loaded.
    logic [5:0] pred_list [MaxNodes][MaxPreds];
    int         pred_len [MaxNodes];
    int         dom_of [MaxNodes];   // -1 means not yet known
    logic [1:0] graph_err;

    edge_beat_t edge_queue[$];
    dom_beat_t  dom_expected[$];
    int         failures;
    int         idle_cycles;
    bit         busy_phase;          // a stretch with no idling on either side
    bit         stimulus_done;

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    function automatic void clear_graph();
        for (int n = 0; n < MaxNodes; n++)
        begin
            pred_len[n] = 0;
            dom_of[n] = -1;
        end
        graph_err = ERR_OK;
    endfunction

    function automatic void add_result(dom_beat_t r);
        dom_expected.insert(dom_expected.size(), r);
    endfunction

    // Two-finger walk up the current dominator guesses, bounded as in the block.
    function automatic int meet_walk(int a, int b);
        int budget;
        budget = 2 * MaxNodes;
        while (a != b && budget > 0)
        begin
            budget--;
            if (a < b)
                a = (dom_of[a] >= 0) ? dom_of[a] : a;
            else
                b = (dom_of[b] >= 0) ? dom_of[b] : b;
        end
        return a;
    endfunction

    // Absorb one accepted edge; on the last edge queue the expected dominators.
    function automatic void predict_dominators(edge_beat_t e);
        int cnt;
        int ent;
        bit bad;
        bit moved;
        int pick;
        int p;
        dom_beat_t r;
        cnt = e.node_count;
        ent = e.entry_node;
        if (pred_len[e.node] >= MaxPreds)
        begin
            if (graph_err == ERR_OK)
                graph_err = ERR_OVERFLOW;
        end
        else
        begin
            pred_list[e.node][pred_len[e.node]] = e.pred_node;
            pred_len[e.node]++;
        end
        if (!e.last_edge)
            return;
        if (graph_err == ERR_OK)
        begin
            bad = (cnt == 0) || (cnt > MaxNodes) || (ent >= cnt);
            for (int n = 0; n < MaxNodes; n++)
            begin
                if (pred_len[n] != 0 && n >= cnt)
                    bad = 1'b1;
                for (int i = 0; i < pred_len[n]; i++)
                    if (pred_list[n][i] >= cnt)
                        bad = 1'b1;
            end
            if (bad)
                graph_err = ERR_INDEX;
        end
        if (graph_err != ERR_OK)
        begin
            r = '{out_node: '0, idom: '0, reachable: 1'b0, error: graph_err, last: 1'b1};
            add_result(r);
            clear_graph();
            return;
        end
        dom_of[ent] = ent;
        moved = 1'b1;
        for (int pass = 0; moved && pass < cnt + 3; pass++)
        begin
            moved = 1'b0;
            for (int b = cnt - 1; b >= 0; b--)
            begin
                if (b == ent)
                    continue;
                pick = -1;
                for (int i = 0; i < pred_len[b]; i++)
                begin
                    p = pred_list[b][i];
                    if (dom_of[p] < 0)
                        continue;
                    pick = (pick < 0) ? p : meet_walk(p, pick);
                end
                if (pick >= 0 && dom_of[b] != pick)
                begin
                    dom_of[b] = pick;
                    moved = 1'b1;
                end
            end
        end
        for (int k = 0; k < cnt; k++)
        begin
            r.out_node = 6'(k);
            r.idom = 6'((dom_of[k] >= 0) ? dom_of[k] : 0);
            r.reachable = (dom_of[k] >= 0);
            r.error = ERR_OK;
            r.last = (k + 1 == cnt);
            add_result(r);
        end
        clear_graph();
    endfunction

    function automatic void queue_edge(int n, int p, int cnt, int ent, bit fin);
        edge_beat_t e;
        e.node = 6'(n);
        e.pred_node = 6'(p);
        e.node_count = 7'(cnt);
        e.entry_node = 6'(ent);
        e.last_edge = fin;
        edge_queue.insert(edge_queue.size(), e);
    endfunction

    // Build a well-formed graph: every edge mostly goes from a higher post-order
    // number to a lower one (forward), with a few back edges, entry at top.
    function automatic void queue_graph(int cnt, int extra);
        int ent;
        int nedges;
        int n;
        int p;
        int used [MaxNodes];
        for (int i = 0; i < MaxNodes; i++)
            used[i] = 0;
        ent = cnt - 1;
        nedges = 0;
        for (int b = cnt - 2; b >= 0; b--)
        begin
            if ($urandom_range(0, 9) == 0)
                continue;  // leave some nodes unreachable
            queue_edge(b, $urandom_range(b + 1, cnt - 1), 0, 0, 0);
            used[b]++;
        end
        for (int i = 0; i < extra; i++)
        begin
            n = $urandom_range(0, cnt - 1);
            p = ($urandom_range(0, 4) == 0) ? $urandom_range(0, cnt - 1)
                                            : $urandom_range(n, cnt - 1);
            if (used[n] < MaxPreds - 1)
            begin
                queue_edge(n, p, 0, 0, 0);
                used[n]++;
            end
        end
        // closing edge: a harmless duplicate-style entry self loop
        queue_edge(ent, ent, cnt, ent, 1);
    endfunction

    initial
    begin
        int kind;
        int cnt;
        failures = 0;
        stimulus_done = 1'b0;
        clear_graph();
        // Directed: single node, two-node chain, diamond, overflow, full-size graph, bad indexes.
        queue_edge(0, 0, 1, 0, 1);
        queue_edge(0, 1, 0, 0, 0);
        queue_edge(1, 1, 2, 1, 1);
        queue_edge(1, 3, 0, 0, 0);
        queue_edge(2, 3, 0, 0, 0);
        queue_edge(0, 1, 0, 0, 0);
        queue_edge(0, 2, 4, 3, 1);
        for (int i = 0; i < MaxPreds; i++)
            queue_edge(0, 1, 0, 0, 0);
        queue_edge(0, 1, 2, 1, 1);              // predecessor table overflow
        queue_edge(63, 63, 64, 63, 1);          // max node, max count, self loop
        queue_edge(0, 1, 0, 0, 0);
        queue_edge(0, 0, 7'd127, 0, 1);         // count beyond limit
        queue_edge(0, 0, 0, 0, 1);              // zero count
        queue_edge(0, 0, 3, 5, 1);              // entry out of range
        queue_edge(5, 0, 3, 0, 1);              // node out of range
        // Random: mostly well-formed graphs, some noise graphs.
        while (edge_queue.size() < 285)
        begin
            kind = $urandom_range(0, 9);
            cnt = (edge_queue.size() < 200 && $urandom_range(0, 15) == 0)
                  ? $urandom_range(40, 64) : $urandom_range(2, 12);
            if (kind < 8)
                queue_graph(cnt, $urandom_range(0, cnt));
            else
            begin
                for (int i = 0; i < $urandom_range(0, 10); i++)
                    queue_edge($urandom_range(0, 63), $urandom_range(0, 63),
                               $urandom_range(0, 127), $urandom_range(0, 63), 0);
                queue_edge($urandom_range(0, 63), $urandom_range(0, 63),
                           $urandom_range(0, 127), $urandom_range(0, 63), 1);
            end
        end
        stimulus_done = 1'b1;
    end

    // Reset, then decide when idling is switched off for a stretch.
    initial
    begin
        rst_n = 1'b0;
        busy_phase = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3000) @(posedge clk);
        busy_phase <= 1'b1;
        repeat (4000) @(posedge clk);
        busy_phase <= 1'b0;
    end

    // Driver: hold each edge until accepted, idle at random between beats.
    always @(posedge clk or negedge rst_n)
    begin
        edge_beat_t e;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            node <= '0;
            pred_node <= '0;
            node_count <= '0;
            entry_node <= '0;
            last_edge <= 1'b0;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= busy_phase || ($urandom_range(0, 99) >= 16);
            if (!in_valid || in_ready)
            begin
                if (edge_queue.size() != 0 && (busy_phase || $urandom_range(0, 99) >= 16))
                begin
                    e = edge_queue.pop_front();
                    in_valid <= 1'b1;
                    node <= e.node;
                    pred_node <= e.pred_node;
                    node_count <= e.node_count;
                    entry_node <= e.entry_node;
                    last_edge <= e.last_edge;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: predict on accepted edges, compare accepted result beats.
    always @(posedge clk)
    begin
        dom_beat_t got;
        dom_beat_t want;
        bit took;
        if (rst_n)
        begin
            took = 1'b0;
            if (in_valid && in_ready)
            begin
                took = 1'b1;
                predict_dominators('{node, pred_node, node_count, entry_node, last_edge});
            end
            if (out_valid && out_ready)
            begin
                took = 1'b1;
                got = '{out_node, idom, reachable, error, last};
                if (dom_expected.size() == 0)
                begin
                    $display("%0t: unexpected result beat, actual %p", $time, got);
                    failures++;
                end
                else
                begin
                    want = dom_expected.pop_front();
                    if (got !== want)
                    begin
                        $display("%0t: result mismatch, expected %p, actual %p",
                                 $time, want, got);
                        failures++;
                    end
                end
            end
            idle_cycles <= took ? 0 : idle_cycles + 1;
        end
        else
            idle_cycles <= 0;
    end

    // End of run: drain expectations, allow a settling tail, then report.
    initial
    begin
        @(posedge rst_n);
        while (!(stimulus_done && edge_queue.size() == 0 && !in_valid
                 && dom_expected.size() == 0) && idle_cycles < WatchdogLimit)
            @(posedge clk);
        if (idle_cycles >= WatchdogLimit)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            repeat (200) @(posedge clk);
            if (failures == 0 && dom_expected.size() == 0)
                $display("simulation ok");
            else
                $display("simulation failed");
            $finish;
        end
    end
endmodule
